/* rtl/core/pff_pkg.sv */
// shared types, codes and tables for the pd formation follower
`default_nettype none
package pff_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LINEAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ANGULAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FWD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SIDE   = 3'd5;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;

    localparam int          STEP_W    = 4;
    localparam logic [3:0]  LAST_STEP = 4'd15;
    localparam int          IDX_W     = 5;
    localparam int          VX_W      = 38;
    localparam int          SPLIT     = 19;
    localparam longint      INV_GAIN_Q30 = 64'sd652032874;

    typedef enum logic [3:0] {
        A_OFF_FWD, A_OFF_SIDE, A_EX, A_EY, A_DX, A_DY, A_VXH, A_VXL, A_VYH, A_VYL
    } t_a_sel;

    typedef enum logic [2:0] {B_LC, B_LS, B_OC, B_OS, B_GP, B_GD} t_b_sel;

    typedef enum logic [1:0] {BIAS_TGT_X, BIAS_TGT_Y, BIAS_PD, BIAS_BODY} t_bias;

    typedef enum logic [2:0] {WB_NONE, WB_EX, WB_EY, WB_VX, WB_VY, WB_LIN, WB_ANG} t_wb;

    typedef struct packed {
        t_a_sel a_sel;
        t_b_sel b_sel;
        logic   neg;
        logic   shl;
        logic   clr;
        t_bias  bias;
        t_wb    wb;
    } t_mac_step;

    typedef struct packed {
        logic             load;
        logic             clr_err;
        logic             cor_init;
        logic             cor_step;
        logic             cor_store;
        logic             cor_own;
        logic [IDX_W-1:0] idx;
        logic             mul;
        logic             acc;
        logic             wb;
        logic             out_load;
        logic             out_zero;
    } t_dp_cmd;

    function automatic logic [31:0] ang_tab(input logic [IDX_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // multiply-accumulate program: target, pd law, body rotation
    function automatic t_mac_step mac_step(input logic [STEP_W-1:0] k);
        t_mac_step s;
        unique case (k)
            4'd0:  s = '{A_OFF_FWD,  B_LC, 1'b0, 1'b0, 1'b1, BIAS_TGT_X, WB_NONE};
            4'd1:  s = '{A_OFF_SIDE, B_LS, 1'b1, 1'b0, 1'b0, BIAS_TGT_X, WB_EX};
            4'd2:  s = '{A_OFF_FWD,  B_LS, 1'b0, 1'b0, 1'b1, BIAS_TGT_Y, WB_NONE};
            4'd3:  s = '{A_OFF_SIDE, B_LC, 1'b0, 1'b0, 1'b0, BIAS_TGT_Y, WB_EY};
            4'd4:  s = '{A_EX,       B_GP, 1'b0, 1'b0, 1'b1, BIAS_PD,    WB_NONE};
            4'd5:  s = '{A_DX,       B_GD, 1'b0, 1'b0, 1'b0, BIAS_PD,    WB_VX};
            4'd6:  s = '{A_EY,       B_GP, 1'b0, 1'b0, 1'b1, BIAS_PD,    WB_NONE};
            4'd7:  s = '{A_DY,       B_GD, 1'b0, 1'b0, 1'b0, BIAS_PD,    WB_VY};
            4'd8:  s = '{A_VXH,      B_OC, 1'b0, 1'b1, 1'b1, BIAS_BODY,  WB_NONE};
            4'd9:  s = '{A_VXL,      B_OC, 1'b0, 1'b0, 1'b0, BIAS_BODY,  WB_NONE};
            4'd10: s = '{A_VYH,      B_OS, 1'b0, 1'b1, 1'b0, BIAS_BODY,  WB_NONE};
            4'd11: s = '{A_VYL,      B_OS, 1'b0, 1'b0, 1'b0, BIAS_BODY,  WB_LIN};
            4'd12: s = '{A_VYH,      B_OC, 1'b0, 1'b1, 1'b1, BIAS_BODY,  WB_NONE};
            4'd13: s = '{A_VYL,      B_OC, 1'b0, 1'b0, 1'b0, BIAS_BODY,  WB_NONE};
            4'd14: s = '{A_VXH,      B_OS, 1'b1, 1'b1, 1'b0, BIAS_BODY,  WB_NONE};
            4'd15: s = '{A_VXL,      B_OS, 1'b1, 1'b0, 1'b0, BIAS_BODY,  WB_ANG};
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/pff_ctrl.sv */
// controller state machine: sequences cordic, mac program and result hand-off
`default_nettype none
module pff_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic [1:0]      i_opcode,
    input  wire logic            i_own_ok,
    input  wire logic            i_lead_ok,
    input  wire logic            i_m_tready,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    output pff_pkg::t_dp_cmd     o_cmd
);
    import pff_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [IW-1:0] CNT_LAST = IW'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CINIT, S_CSTEP, S_CSTORE, S_MUL, S_ACC, S_WB, S_EMIT
    } t_state;

    t_state              r_state;
    logic   [IW-1:0]     r_cnt;
    logic   [STEP_W-1:0] r_k;
    logic                r_own;
    logic                r_zero;
    logic                r_out_valid;
    logic                w_accept;
    logic                w_out_free;
    t_mac_step           w_step;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign w_accept   = i_s_tvalid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_step     = mac_step(r_k);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_accept;
        o_cmd.clr_err   = w_accept && (i_opcode == OP_RESTART || i_opcode == OP_STOP);
        o_cmd.cor_init  = (r_state == S_CINIT);
        o_cmd.cor_step  = (r_state == S_CSTEP);
        o_cmd.cor_store = (r_state == S_CSTORE);
        o_cmd.cor_own   = r_own;
        o_cmd.idx       = (r_state == S_CSTEP) ? IDX_W'(r_cnt) : IDX_W'(r_k);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.acc       = (r_state == S_ACC);
        o_cmd.wb        = (r_state == S_WB);
        o_cmd.out_load  = (r_state == S_EMIT) && w_out_free;
        o_cmd.out_zero  = r_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_own       <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_opcode == OP_STOP) begin
                            r_zero  <= 1'b1;
                            r_state <= S_EMIT;
                        end else if (i_opcode == OP_TICK && i_own_ok && i_lead_ok) begin
                            r_zero  <= 1'b0;
                            r_own   <= 1'b0;
                            r_state <= S_CINIT;
                        end
                    end
                end
                S_CINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_CSTEP;
                end
                S_CSTEP: begin
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_CSTORE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CSTORE: begin
                    if (!r_own) begin
                        r_own   <= 1'b1;
                        r_state <= S_CINIT;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    if (w_step.wb != WB_NONE) begin
                        r_state <= S_WB;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_WB: begin
                    if (r_k == LAST_STEP) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/pff_dpath.sv */
// datapath: config registers, cordic unit, shared multiplier and accumulator
`default_nettype none
module pff_dpath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pff_pkg::t_dp_cmd                   i_cmd,
    input  wire logic                               i_cfg_we,
    input  wire logic [pff_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [pff_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic signed [31:0]                 i_own_x,
    input  wire logic signed [31:0]                 i_own_y,
    input  wire logic [15:0]                        i_own_heading,
    input  wire logic signed [31:0]                 i_lead_x,
    input  wire logic signed [31:0]                 i_lead_y,
    input  wire logic [15:0]                        i_lead_heading,
    output logic signed [31:0]                      o_lin_rate,
    output logic signed [31:0]                      o_ang_rate
);
    import pff_pkg::*;

    localparam int CW = FRAC_BITS + 3;
    localparam int BW = (CW > 17) ? CW : 17;
    localparam int PW = 34 + BW;
    localparam int AW = FRAC_BITS + 42;
    localparam int RS = 30 - FRAC_BITS;
    localparam longint X0L = (INV_GAIN_Q30 + (64'sd1 <<< (RS - 1))) >>> RS;
    localparam logic signed [CW-1:0] X0 = CW'(X0L);
    localparam logic signed [AW-1:0] HALF_F =
        {{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [AW-1:0] HALF_PD = {{(AW-8){1'b0}}, 8'h80};
    localparam logic signed [AW-1:0] I32_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [AW-1:0] I32_MIN = {{(AW-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [AW-1:0] PD_MAX  = {{(AW-37){1'b0}}, {37{1'b1}}};
    localparam logic signed [AW-1:0] PD_MIN  = -PD_MAX;

    // configuration and error memory
    logic [15:0]           r_gp, r_gd;
    logic [30:0]           r_ll, r_la;
    logic signed [31:0]    r_off_fwd, r_off_side;
    logic signed [31:0]    r_last_x, r_last_y;
    logic                  w_cfg_clr;

    // captured request
    logic signed [32:0]    r_dlx, r_dly;
    logic [15:0]           r_own_hd, r_lead_hd;

    // cordic
    logic signed [CW-1:0]  r_cx, r_cy;
    logic signed [33:0]    r_cz;
    logic                  r_cflip;
    logic signed [CW-1:0]  r_lc, r_ls, r_oc, r_os;
    logic [15:0]           w_hd;
    logic [31:0]           w_ang;
    logic                  w_flip;
    logic signed [CW-1:0]  w_xs, w_ys, w_c, w_s;
    logic signed [33:0]    w_tab;

    // mac
    t_mac_step             w_step;
    logic signed [33:0]    w_a;
    logic signed [BW-1:0]  w_b;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  r_acc;
    logic signed [AW-1:0]  w_pe, w_ps, w_pn, w_bias;
    logic signed [32:0]    w_dx, w_dy;

    // write-back
    logic signed [31:0]    r_ex, r_ey;
    logic signed [VX_W-1:0] r_vx, r_vy;
    logic signed [31:0]    r_lin_w, r_ang_w;
    logic signed [AW-1:0]  w_sh_f, w_sh_8, w_lim, w_nlim;
    logic signed [31:0]    w_e_sat, w_r_sat;
    logic signed [VX_W-1:0] w_v_sat;

    assign w_cfg_clr = i_cfg_we &&
        ((i_cfg_idx == REG_OFFSET_FWD  && i_cfg_data != r_off_fwd) ||
         (i_cfg_idx == REG_OFFSET_SIDE && i_cfg_data != r_off_side));

    assign w_step = mac_step(i_cmd.idx[STEP_W-1:0]);
    assign w_dx   = 33'(r_ex) - 33'(r_last_x);
    assign w_dy   = 33'(r_ey) - 33'(r_last_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp       <= 16'd256;
            r_gd       <= 16'd0;
            r_ll       <= 31'd65536;
            r_la       <= 31'd65536;
            r_off_fwd  <= '0;
            r_off_side <= '0;
            r_last_x   <= '0;
            r_last_y   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GAIN_PROP:     r_gp       <= i_cfg_data[15:0];
                    REG_GAIN_DERIV:    r_gd       <= i_cfg_data[15:0];
                    REG_LIMIT_LINEAR:  r_ll       <= i_cfg_data[30:0];
                    REG_LIMIT_ANGULAR: r_la       <= i_cfg_data[30:0];
                    REG_OFFSET_FWD:    r_off_fwd  <= signed'(i_cfg_data);
                    REG_OFFSET_SIDE:   r_off_side <= signed'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.clr_err || w_cfg_clr) begin
                r_last_x <= '0;
                r_last_y <= '0;
            end else if (i_cmd.wb && w_step.wb == WB_VY) begin
                r_last_x <= r_ex;
                r_last_y <= r_ey;
            end
        end
    end

    // cordic angle prep: fold the back half-plane by a half turn
    assign w_hd   = i_cmd.cor_own ? r_own_hd : r_lead_hd;
    assign w_ang  = {w_hd, 16'h0000};
    assign w_flip = w_ang[31] ^ w_ang[30];
    assign w_xs   = r_cx >>> i_cmd.idx;
    assign w_ys   = r_cy >>> i_cmd.idx;
    assign w_tab  = 34'(ang_tab(i_cmd.idx));
    assign w_c    = r_cflip ? -r_cx : r_cx;
    assign w_s    = r_cflip ? -r_cy : r_cy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dlx     <= 33'(i_lead_x) - 33'(i_own_x);
            r_dly     <= 33'(i_lead_y) - 33'(i_own_y);
            r_own_hd  <= i_own_heading;
            r_lead_hd <= i_lead_heading;
        end
        if (i_cmd.cor_init) begin
            r_cx    <= X0;
            r_cy    <= '0;
            r_cz    <= 34'(signed'({w_ang[31] ^ w_flip, w_ang[30:0]}));
            r_cflip <= w_flip;
        end else if (i_cmd.cor_step) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_tab;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_tab;
            end
        end
        if (i_cmd.cor_store) begin
            if (i_cmd.cor_own) begin
                r_oc <= w_c;
                r_os <= w_s;
            end else begin
                r_lc <= w_c;
                r_ls <= w_s;
            end
        end
    end

    always_comb begin
        unique case (w_step.a_sel)
            A_OFF_FWD:  w_a = 34'(r_off_fwd);
            A_OFF_SIDE: w_a = 34'(r_off_side);
            A_EX:       w_a = 34'(r_ex);
            A_EY:       w_a = 34'(r_ey);
            A_DX:       w_a = 34'(w_dx);
            A_DY:       w_a = 34'(w_dy);
            A_VXH:      w_a = 34'(signed'(r_vx[VX_W-1:SPLIT]));
            A_VXL:      w_a = 34'({1'b0, r_vx[SPLIT-1:0]});
            A_VYH:      w_a = 34'(signed'(r_vy[VX_W-1:SPLIT]));
            A_VYL:      w_a = 34'({1'b0, r_vy[SPLIT-1:0]});
            default:    w_a = '0;
        endcase
        unique case (w_step.b_sel)
            B_LC:    w_b = BW'(r_lc);
            B_LS:    w_b = BW'(r_ls);
            B_OC:    w_b = BW'(r_oc);
            B_OS:    w_b = BW'(r_os);
            B_GP:    w_b = BW'(signed'({1'b0, r_gp}));
            B_GD:    w_b = BW'(signed'({1'b0, r_gd}));
            default: w_b = '0;
        endcase
        // rounding half and the position difference ride in as the start value
        unique case (w_step.bias)
            BIAS_TGT_X: w_bias = AW'(signed'({r_dlx, 1'b1, {(FRAC_BITS-1){1'b0}}}));
            BIAS_TGT_Y: w_bias = AW'(signed'({r_dly, 1'b1, {(FRAC_BITS-1){1'b0}}}));
            BIAS_PD:    w_bias = HALF_PD;
            BIAS_BODY:  w_bias = HALF_F;
            default:    w_bias = '0;
        endcase
    end

    assign w_pe = AW'(r_prod);
    assign w_ps = w_step.shl ? (w_pe <<< SPLIT) : w_pe;
    assign w_pn = w_step.neg ? -w_ps : w_ps;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_a * w_b;
        end
        if (i_cmd.acc) begin
            r_acc <= (w_step.clr ? w_bias : r_acc) + w_pn;
        end
    end

    assign w_sh_f = r_acc >>> FRAC_BITS;
    assign w_sh_8 = r_acc >>> 8;
    assign w_lim  = (w_step.wb == WB_ANG) ? AW'(signed'({1'b0, r_la}))
                                          : AW'(signed'({1'b0, r_ll}));
    assign w_nlim = -w_lim;

    always_comb begin
        priority if (w_sh_f > I32_MAX) w_e_sat = I32_MAX[31:0];
        else if (w_sh_f < I32_MIN)     w_e_sat = I32_MIN[31:0];
        else                           w_e_sat = w_sh_f[31:0];
        priority if (w_sh_8 > PD_MAX)  w_v_sat = PD_MAX[VX_W-1:0];
        else if (w_sh_8 < PD_MIN)      w_v_sat = PD_MIN[VX_W-1:0];
        else                           w_v_sat = w_sh_8[VX_W-1:0];
        priority if (w_sh_f > w_lim)   w_r_sat = w_lim[31:0];
        else if (w_sh_f < w_nlim)      w_r_sat = w_nlim[31:0];
        else                           w_r_sat = w_sh_f[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            unique case (w_step.wb)
                WB_EX:   r_ex    <= w_e_sat;
                WB_EY:   r_ey    <= w_e_sat;
                WB_VX:   r_vx    <= w_v_sat;
                WB_VY:   r_vy    <= w_v_sat;
                WB_LIN:  r_lin_w <= w_r_sat;
                WB_ANG:  r_ang_w <= w_r_sat;
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            o_lin_rate <= i_cmd.out_zero ? '0 : r_lin_w;
            o_ang_rate <= i_cmd.out_zero ? '0 : r_ang_w;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/pd_formation_follower_core.sv */
// top level of the pd formation follower: stream ports, controller and datapath
`default_nettype none
// Leader-follower PD formation controller. A control tick (tuser 0) with both
// poses valid runs two CORDIC sin/cos evaluations (leader then follower heading,
// CORDIC_STEPS iterations each) followed by a 16-step program on one shared
// multiplier and accumulator, whose result goes to the output register. Restart
// (tuser 1) clears the stored error with no result; stop (tuser 2) clears it and
// delivers zero rates; invalid ticks and tuser 3 are dropped. A new request is
// accepted while the previous result still waits in the output register.
// Configuration writes are taken in the cycle they are presented.
module pd_formation_follower_core #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // own_x, own_y, own_heading, own_ok, lead_x, lead_y, lead_heading, lead_ok
    input  wire logic [167:0]                   i_s_tdata,
    // opcode
    input  wire logic [1:0]                     i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // lin_rate, ang_rate
    output logic [63:0]                         o_m_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [pff_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pff_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pff_pkg::*;

    t_dp_cmd            w_cmd;
    logic signed [31:0] w_lin, w_ang;

    pff_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_opcode   (i_s_tuser),
        .i_own_ok   (i_s_tdata[80]),
        .i_lead_ok  (i_s_tdata[161]),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    pff_dpath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_own_x        (signed'(i_s_tdata[31:0])),
        .i_own_y        (signed'(i_s_tdata[63:32])),
        .i_own_heading  (i_s_tdata[79:64]),
        .i_lead_x       (signed'(i_s_tdata[112:81])),
        .i_lead_y       (signed'(i_s_tdata[144:113])),
        .i_lead_heading (i_s_tdata[160:145]),
        .o_lin_rate     (w_lin),
        .o_ang_rate     (w_ang)
    );

    assign o_m_tdata = {w_ang, w_lin};

`ifndef SYNTHESIS
    // at most one datapath action per cycle
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.cor_init, w_cmd.cor_step, w_cmd.cor_store,
                  w_cmd.mul, w_cmd.acc, w_cmd.wb, w_cmd.out_load}))
        else $error("more than one datapath action in a cycle");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten before it was taken");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_m_tvalid)
        else $error("loaded result not presented");

    // the input side is closed while a computation runs
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.cor_step || w_cmd.mul || w_cmd.acc) |-> !o_s_tready)
        else $error("request accepted during computation");
`endif

endmodule
`default_nettype wire

/* tb/pd_formation_follower_core_checker.sv */
// checker for the pd formation follower: predicts body rates and compares them
`default_nettype none
module pd_formation_follower_core_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [167:0]                   i_s_tdata,
    input  wire logic [1:0]                     i_s_tuser,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [63:0]                    i_m_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [pff_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pff_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_pending,
    output int                                  o_fail_cnt
);
    import pff_pkg::*;

    typedef struct {
        logic [31:0] lin;
        logic [31:0] ang;
    } t_rates;

    localparam int     FRAC    = 16;
    localparam int     N_ITER  = 16;
    localparam longint PD_LIM  = (64'sd1 <<< 37) - 1;

    logic [31:0] atan_lut [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    longint gp, gd, lim_lin, lim_ang, off_f, off_s, prev_ex, prev_ey;
    t_rates rate_q[$];

    function automatic longint rnd_shr(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void heading_trig(input logic [15:0] hdg, output longint c,
                                         output longint s);
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, xs, ys;
        a = {hdg, 16'h0};
        flip = a[31] ^ a[30];
        if (flip) a = a + 32'h80000000;
        z = longint'(signed'(a));
        x = rnd_shr(64'sd652032874, 30 - FRAC);
        y = 0;
        for (int i = 0; i < N_ITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(atan_lut[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(atan_lut[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // world-frame pd command rotated into the follower frame, saturated
    function automatic t_rates follow_rates(input logic [167:0] d);
        longint ox, oy, lx, ly, lc, ls, oc, os, ex, ey, vx, vy, lin, ang;
        t_rates r;
        ox = longint'(signed'(d[31:0]));
        oy = longint'(signed'(d[63:32]));
        lx = longint'(signed'(d[112:81]));
        ly = longint'(signed'(d[144:113]));
        heading_trig(d[160:145], lc, ls);
        heading_trig(d[79:64], oc, os);
        ex = clamp(lx + rnd_shr(lc * off_f - ls * off_s, FRAC) - ox,
                   -64'sd2147483648, 64'sd2147483647);
        ey = clamp(ly + rnd_shr(ls * off_f + lc * off_s, FRAC) - oy,
                   -64'sd2147483648, 64'sd2147483647);
        vx = clamp(rnd_shr(gp * ex + gd * (ex - prev_ex), 8), -PD_LIM, PD_LIM);
        vy = clamp(rnd_shr(gp * ey + gd * (ey - prev_ey), 8), -PD_LIM, PD_LIM);
        prev_ex = ex;
        prev_ey = ey;
        lin = clamp(rnd_shr(oc * vx + os * vy, FRAC), -lim_lin, lim_lin);
        ang = clamp(rnd_shr(oc * vy - os * vx, FRAC), -lim_ang, lim_ang);
        r.lin = lin[31:0];
        r.ang = ang[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rates got, want;
        longint v;
        if (!i_rst_n) begin
            gp <= 256; gd <= 0; lim_lin <= 65536; lim_ang <= 65536;
            off_f <= 0; off_s <= 0; prev_ex <= 0; prev_ey <= 0;
            rate_q.delete();
            o_pending <= 0;
            o_fail_cnt <= 0;
        end else begin
            if (i_cfg_we) begin
                v = longint'(signed'(i_cfg_data));
                case (i_cfg_idx)
                    REG_GAIN_PROP:     gp = i_cfg_data[15:0];
                    REG_GAIN_DERIV:    gd = i_cfg_data[15:0];
                    REG_LIMIT_LINEAR:  lim_lin = i_cfg_data[30:0];
                    REG_LIMIT_ANGULAR: lim_ang = i_cfg_data[30:0];
                    REG_OFFSET_FWD: begin
                        if (v != off_f) begin
                            off_f = v; prev_ex = 0; prev_ey = 0;
                        end
                    end
                    REG_OFFSET_SIDE: begin
                        if (v != off_s) begin
                            off_s = v; prev_ex = 0; prev_ey = 0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    OP_RESTART: begin
                        prev_ex = 0; prev_ey = 0;
                    end
                    OP_STOP: begin
                        prev_ex = 0; prev_ey = 0;
                        rate_q.push_back('{32'h0, 32'h0});
                    end
                    OP_TICK: begin
                        if (i_s_tdata[80] && i_s_tdata[161])
                            rate_q.push_back(follow_rates(i_s_tdata));
                    end
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.lin = i_m_tdata[31:0];
                got.ang = i_m_tdata[63:32];
                if (rate_q.size() == 0) begin
                    $error("unexpected result lin_rate=%h ang_rate=%h", got.lin, got.ang);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = rate_q.pop_front();
                    if (got.lin !== want.lin || got.ang !== want.ang)
                        o_fail_cnt <= o_fail_cnt + 1;
                    if (got.lin !== want.lin)
                        $error("lin_rate expected %h actual %h", want.lin, got.lin);
                    if (got.ang !== want.ang)
                        $error("ang_rate expected %h actual %h", want.ang, got.ang);
                end
            end
            o_pending <= rate_q.size();
        end
    end
endmodule
`default_nettype wire

/* tb/pd_formation_follower_core_test.sv */
// testbench top for the pd formation follower: stimulus, watchdog and verdict
`default_nettype none
module pd_formation_follower_core_test;
    import pff_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [167:0]          s_tdata = '0;
    logic [1:0]            s_tuser = OP_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    pending, fail_cnt, quiet_cyc;
    bit                    rx_calm;
    int                    stall_left;

    always #1 i_clk = ~i_clk;

    pd_formation_follower_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    pd_formation_follower_core_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_fail_cnt(fail_cnt)
    );

    // receiver stalls: mostly short, some long, none while calm
    always @(negedge i_clk) begin
        int r;
        logic rdy;
        r = $urandom_range(0, 99);
        rdy = 1'b1;
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rdy = 1'b0;
        end else if (!rx_calm && r < 12) begin
            stall_left = $urandom_range(0, 3);
            rdy = 1'b0;
        end else if (!rx_calm && r < 14) begin
            stall_left = $urandom_range(20, 120);
            rdy = 1'b0;
        end
        m_tready <= rdy;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cyc <= 0;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= 20000) begin
                $display("pd_formation_follower_core regression: fail");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [1:0] op, input logic [31:0] ox, input logic [31:0] oy,
                            input logic [15:0] oh, input logic ook, input logic [31:0] lx,
                            input logic [31:0] ly, input logic [15:0] lh, input logic lok,
                            input int gap);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, lok, lh, ly, lx, ook, oh, oy, ox};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic tick(input logic [31:0] ox, input logic [31:0] oy, input logic [15:0] oh,
                        input logic [31:0] lx, input logic [31:0] ly, input logic [15:0] lh);
        send_req(OP_TICK, ox, oy, oh, 1'b1, lx, ly, lh, 1'b1, 0);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    function automatic logic [31:0] near_value(input logic [31:0] base);
        logic signed [31:0] d;
        d = signed'($urandom) >>> $urandom_range(6, 22);
        return base + d;
    endfunction

    task automatic random_req(input int gap);
        int          r;
        logic [31:0] lx, ly, ox, oy;
        logic        ook, lok;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 7) begin
            lx = signed'($urandom) >>> $urandom_range(0, 16);
            ly = signed'($urandom) >>> $urandom_range(0, 16);
            ox = near_value(lx);
            oy = near_value(ly);
        end else begin
            lx = $urandom; ly = $urandom; ox = $urandom; oy = $urandom;
        end
        ook = 1'b1;
        lok = 1'b1;
        if (r >= 78 && r < 84) begin
            ook = $urandom_range(0, 1);
            lok = ook ? 1'b0 : $urandom_range(0, 1);
        end
        if (r < 84)
            send_req(OP_TICK, ox, oy, $urandom, ook, lx, ly, $urandom, lok, gap);
        else if (r < 90)
            send_req(OP_RESTART, ox, oy, $urandom, ook, lx, ly, $urandom, lok, gap);
        else if (r < 95)
            send_req(OP_STOP, ox, oy, $urandom, ook, lx, ly, $urandom, lok, gap);
        else
            send_req(2'd3, ox, oy, $urandom, ook, lx, ly, $urandom, lok, gap);
    endtask

    function automatic logic [31:0] pick_limit(input int p);
        case (p % 4)
            0: return 32'h7FFFFFFF;
            1: return 32'h0;
            default: return $urandom_range(1, 40) << $urandom_range(12, 20);
        endcase
    endfunction

    initial begin
        logic [31:0] v;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default settings, field extremes and every opcode
        rx_calm = 1'b1;
        tick(32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 16'h0);
        tick(32'h80000000, 32'h80000000, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
        tick(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h4000, 32'h80000000, 32'h80000000, 16'h8000);
        tick(32'h00010000, 32'hFFFF0000, 16'hC000, 32'h00008000, 32'h00004000, 16'h3FFF);
        tick(32'h0, 32'h0, 16'h8000, 32'h00001000, 32'hFFFFF000, 16'h4001);
        tick(32'h0, 32'h0, 16'h2000, 32'h00001000, 32'hFFFFF000, 16'hBFFF);
        send_req(OP_TICK, 32'h1, 32'h1, 16'h1, 1'b0, 32'h5, 32'h5, 16'h1, 1'b1, 0);
        send_req(OP_TICK, 32'h1, 32'h1, 16'h1, 1'b1, 32'h5, 32'h5, 16'h1, 1'b0, 0);
        send_req(OP_TICK, 32'h1, 32'h1, 16'h1, 1'b0, 32'h5, 32'h5, 16'h1, 1'b0, 0);
        send_req(OP_RESTART, 32'h0, 32'h0, 16'h0, 1'b1, 32'h0, 32'h0, 16'h0, 1'b1, 0);
        send_req(OP_STOP, 32'h0, 32'h0, 16'h0, 1'b1, 32'h0, 32'h0, 16'h0, 1'b1, 0);
        send_req(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1,
                 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 0);
        tick(32'h00020000, 32'h00030000, 16'h1234, 32'h00050000, 32'h00010000, 16'h5678);
        drain_results();

        // pd law with derivative and huge command saturation
        cfg_write(REG_GAIN_PROP, 32'hFFFF);
        cfg_write(REG_GAIN_DERIV, 32'hFFFF);
        cfg_write(REG_LIMIT_LINEAR, 32'h7FFFFFFF);
        cfg_write(REG_LIMIT_ANGULAR, 32'hFFFFFFFF);
        cfg_write(REG_OFFSET_FWD, 32'h7FFFFFFF);
        cfg_write(REG_OFFSET_SIDE, 32'h80000000);
        cfg_write(3'd6, 32'h12345678);
        cfg_write(3'd7, 32'hFFFFFFFF);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        tick(32'h80000000, 32'h7FFFFFFF, 16'h0, 32'h7FFFFFFF, 32'h80000000, 16'h2000);
        tick(32'h0, 32'h0, 16'h6000, 32'h0, 32'h0, 16'hE000);
        drain_results();

        // equal offset writes leave the stored error alone
        tick(32'h00100000, 32'h0, 16'h0, 32'h0, 32'h00100000, 16'h0);
        drain_results();
        cfg_write(REG_OFFSET_FWD, 32'h7FFFFFFF);
        cfg_write(REG_OFFSET_SIDE, 32'h80000000);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        tick(32'h00100000, 32'h0, 16'h0, 32'h0, 32'h00100000, 16'h0);

        for (int p = 0; p < 9; p++) begin
            drain_results();
            rx_calm = (p % 3 == 1);
            v = (p % 3 == 0) ? 32'h0 : ((p % 3 == 1) ? 32'hFFFF : $urandom_range(0, 2048));
            cfg_write(REG_GAIN_PROP, v);
            cfg_write(REG_GAIN_DERIV, (p % 4 == 2) ? 32'h0 : $urandom_range(0, 4096));
            cfg_write(REG_LIMIT_LINEAR, pick_limit(p));
            cfg_write(REG_LIMIT_ANGULAR, pick_limit(p + 1));
            cfg_write(REG_OFFSET_FWD, (p == 3) ? 32'h80000000 : signed'($urandom) >>> 10);
            cfg_write(REG_OFFSET_SIDE, (p == 5) ? 32'h7FFFFFFF : signed'($urandom) >>> 10);
            @(negedge i_clk);
            cfg_we <= 1'b0;
            for (int n = 0; n < 90; n++)
                random_req(rx_calm ? 0 : pick_gap());
        end
        drain_results();
        repeat (200) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("pd_formation_follower_core regression: pass");
        else
            $display("pd_formation_follower_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
